FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the tracker.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HMT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/hmt_pkg.sv
// Shared types, codes and constants of the heartbeat membership tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hmt_pkg;

	localparam int NODES   = 16;
	localparam int IDX_W   = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int SLOT_W  = 4;
	localparam int STATE_W = 3;
	localparam int STAMP_W = 32;
	localparam int INC_W   = 32;
	localparam int CNT_W   = 8;
	localparam int LIMIT_W = 8;
	localparam int ID_W    = 5;
	localparam int EVENT_W = 3;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [CNT_W-1:0]   CNT_MAX        = '1;
	localparam logic [LIMIT_W-1:0] MISS_LIMIT_RST = 8'd10;
	localparam logic [ID_W-1:0]    OWN_ID_RST     = 5'd1;

	typedef enum logic {
		REG_MISS_LIMIT,
		REG_OWN_NODE_ID
	} reg_idx_t;

	typedef enum logic [STATE_W-1:0] {
		ST_NONE,
		ST_EVICT,
		ST_INIT,
		ST_RUN,
		ST_MASTER
	} node_state_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE,
		EV_OFFLINE,
		EV_TIMEOUT,
		EV_UNDEAD,
		EV_JOINED,
		EV_MASTER,
		EV_FOLLOW
	} event_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] miss_limit;
		logic [ID_W-1:0]    own_node_id;
	} cfg_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [STATE_W-1:0] rstate;
		logic [STAMP_W-1:0] stamp;
		logic [INC_W-1:0]   inc;
		logic               master;
	} req_t;

	typedef struct packed {
		logic [STAMP_W-1:0] last_stamp;
		logic [CNT_W-1:0]   miss;
		logic [CNT_W-1:0]   seen;
		node_state_t        state;
		logic [INC_W-1:0]   joined;
		logic [INC_W-1:0]   evicted;
	} entry_t;

	typedef struct packed {
		event_t      ev;
		logic        evict;
		logic        member;
		node_state_t tracked;
	} res_t;

endpackage

FILE: rtl/hmt_cfg.sv
// Configuration registers behind the APB-style port: miss limit and own node id.
// Depends on hmt_pkg.
`timescale 1ns / 1ps

module hmt_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic                      reg_sel,
	input  logic [hmt_pkg::DATA_W-1:0] pwdata,
	output logic [hmt_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output hmt_pkg::cfg_t             cfg
);
	import hmt_pkg::*;

	logic [LIMIT_W-1:0] miss_limit_q;
	logic [ID_W-1:0]    own_node_id_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_limit_q  <= MISS_LIMIT_RST;
			own_node_id_q <= OWN_ID_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(reg_sel))
				REG_MISS_LIMIT:  miss_limit_q  <= pwdata[LIMIT_W-1:0];
				REG_OWN_NODE_ID: own_node_id_q <= pwdata[ID_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(reg_sel))
			REG_MISS_LIMIT:  prdata = DATA_W'(miss_limit_q);
			REG_OWN_NODE_ID: prdata = DATA_W'(own_node_id_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.miss_limit  = miss_limit_q;
	assign cfg.own_node_id = own_node_id_q;

endmodule

FILE: rtl/hmt_rules.sv
// Heartbeat bookkeeping and transition rules for one table entry.
// Pure combinational logic; depends on hmt_pkg.
`timescale 1ns / 1ps

module hmt_rules (
	input  hmt_pkg::req_t   req,
	input  hmt_pkg::cfg_t   cfg,
	input  hmt_pkg::entry_t cur,
	output hmt_pkg::entry_t nxt,
	output hmt_pkg::res_t   res,
	output logic            hit
);
	import hmt_pkg::*;

	node_state_t r;
	node_state_t s;
	logic        own;
	logic        r_running;
	logic        s_running;
	entry_t      upd;

	always_comb begin
		r         = (req.rstate > ST_MASTER) ? ST_NONE : node_state_t'(req.rstate);
		own       = (({1'b0, req.slot} + 5'd1) == cfg.own_node_id);
		r_running = (r >= ST_INIT);
		s         = cur.state;
		s_running = (s >= ST_INIT);
		hit       = (int'(req.slot) < NODES);

		upd = cur;
		if (!own && r_running) begin
			if (req.stamp == cur.last_stamp) begin
				if (cur.miss != CNT_MAX) begin
					upd.miss = cur.miss + 8'd1;
				end
			end else begin
				upd.miss = '0;
				if (cur.seen != CNT_MAX) begin
					upd.seen = cur.seen + 8'd1;
				end
				upd.last_stamp = req.stamp;
			end
		end

		nxt         = upd;
		res.ev      = EV_NONE;
		res.evict   = 1'b0;
		res.member  = 1'b0;

		if ((s != ST_NONE && r <= ST_EVICT) ||
				(cur.joined != '0 && cur.joined != req.inc)) begin
			if (r != ST_EVICT) begin
				nxt.evicted = '0;
			end
			nxt.joined = '0;
			nxt.seen   = '0;
			nxt.miss   = '0;
			nxt.state  = ST_NONE;
			res.ev     = EV_OFFLINE;
		end else if (upd.miss > cfg.miss_limit && r_running) begin
			res.evict = req.master;
			if (r >= ST_RUN) begin
				nxt.seen = '0;
			end
			nxt.state   = ST_EVICT;
			nxt.evicted = req.inc;
			res.ev      = EV_TIMEOUT;
		end else if (cur.evicted != '0 && cur.evicted == req.inc) begin
			res.evict = 1'b1;
			res.ev    = EV_UNDEAD;
		end else if (upd.seen > (cfg.miss_limit >> 1) && !s_running) begin
			nxt.state  = ST_RUN;
			nxt.joined = req.inc;
			res.member = 1'b1;
			res.ev     = EV_JOINED;
		end else if (s == ST_RUN && r == ST_MASTER) begin
			nxt.state  = ST_MASTER;
			res.member = 1'b1;
			res.ev     = EV_MASTER;
		end else if (s_running) begin
			nxt.state  = r;
			res.member = 1'b1;
			res.ev     = EV_FOLLOW;
		end

		res.tracked = nxt.state;

		if (!hit) begin
			res.ev      = EV_NONE;
			res.evict   = 1'b0;
			res.member  = 1'b0;
			res.tracked = ST_NONE;
		end
	end

endmodule

FILE: rtl/hmt_table.sv
// Per-node register table with its read-modify-write through hmt_rules.
// Depends on hmt_pkg and hmt_rules.
`timescale 1ns / 1ps

module hmt_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  hmt_pkg::req_t req,
	input  hmt_pkg::cfg_t cfg,
	output hmt_pkg::res_t res
);
	import hmt_pkg::*;

	entry_t           tbl_q [NODES];
	logic [IDX_W-1:0] idx;
	entry_t           cur;
	entry_t           nxt;
	logic             hit;

	assign idx = req.slot[IDX_W-1:0];
	assign cur = tbl_q[idx];

	hmt_rules u_rules (
		.req (req),
		.cfg (cfg),
		.cur (cur),
		.nxt (nxt),
		.res (res),
		.hit (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				tbl_q[i] <= entry_t'('0);
			end
		end else if (fire && hit) begin
			tbl_q[idx] <= nxt;
		end
	end

endmodule

FILE: rtl/heartbeat_membership_tracker.sv
// A request is held in the input register, its result in the result register.
// One request per cycle while out_stall does not hold the result register; the
// per-node register table is read-modify-written between the two.
// Reset clears every table entry, both pipeline stages and sets the miss limit
// to 10 and the own node id to 1. Configuration takes effect on the next request.
`timescale 1ns / 1ps

module heartbeat_membership_tracker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hmt_pkg::ADDR_W-1:0]   paddr,
	input  logic [hmt_pkg::DATA_W-1:0]   pwdata,
	output logic [hmt_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [hmt_pkg::SLOT_W-1:0]   slot,
	input  logic [hmt_pkg::STATE_W-1:0]  reported_state,
	input  logic [hmt_pkg::STAMP_W-1:0]  stamp,
	input  logic [hmt_pkg::INC_W-1:0]    reported_incarnation,
	input  logic                         i_am_master,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [hmt_pkg::EVENT_W-1:0]  event_res,
	output logic                         send_evict,
	output logic                         member,
	output logic [hmt_pkg::STATE_W-1:0]  tracked_state
);
	import hmt_pkg::*;

	cfg_t cfg;
	req_t req_s1;
	logic valid_s1;
	res_t res;
	res_t res_s2;
	logic valid_s2;
	logic advance;
	logic accept;
	logic fire;

	hmt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.reg_sel (paddr[ADDR_W-1]),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.slot   <= slot;
			req_s1.rstate <= reported_state;
			req_s1.stamp  <= stamp;
			req_s1.inc    <= reported_incarnation;
			req_s1.master <= i_am_master;
		end
	end

	hmt_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign event_res     = res_s2.ev;
	assign send_evict    = res_s2.evict;
	assign member        = res_s2.member;
	assign tracked_state = res_s2.tracked;

endmodule

FILE: rtl/hmt_checker.sv
// Port-level checker for the heartbeat membership tracker, bound to the top level.
// Depends on hmt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hmt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [hmt_pkg::EVENT_W-1:0]  event_res,
	input logic                         send_evict,
	input logic                         member,
	input logic [hmt_pkg::STATE_W-1:0]  tracked_state
);
	import hmt_pkg::*;

	`HMT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "Stalled result dropped.")
	`HMT_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(event_res) && $stable(tracked_state), "Stalled result changed.")
	`HMT_ASSERT_SAME(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "Input stalled while the result side can move.")
	`HMT_ASSERT_SAME(a_offline, clk, arst_n, out_valid && event_res == EV_OFFLINE, tracked_state == ST_NONE && !member && !send_evict, "Offline result is inconsistent.")
	`HMT_ASSERT_SAME(a_member_evict, clk, arst_n, out_valid && member, !send_evict, "Member flagged for eviction.")

endmodule

bind heartbeat_membership_tracker hmt_checker u_hmt_checker (.*);
